### rtl/core/f2f_pkg.sv
// ----------------------------------------------------------------------------
// f2f_pkg
// Shared types and constants for the fixed-to-float vector converter.
// ----------------------------------------------------------------------------
package f2f_pkg;
	localparam int unsigned Lanes    = 4;
	localparam int unsigned MantBits = 23;
	localparam logic [7:0]  ExpBias  = 8'd127;

	localparam logic [1:0] FUNC_NONE    = 2'd0;
	localparam logic [1:0] FUNC_FOUR    = 2'd1;
	localparam logic [1:0] FUNC_TWELVE  = 2'd2;
	localparam logic [1:0] FUNC_FIFTEEN = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic signed [31:0] x_in;
		logic signed [31:0] y_in;
		logic signed [31:0] z_in;
		logic signed [31:0] w_in;
	} in_item_t;

	typedef struct packed {
		logic [31:0] x_out;
		logic [31:0] y_out;
		logic [31:0] z_out;
		logic [31:0] w_out;
	} out_item_t;

	// Lane state after normalization, between stage 1 and stage 2.
	typedef struct packed {
		logic        zero;
		logic        sign;
		logic [4:0]  top;
		logic [31:0] norm;   // magnitude shifted so its leading one is bit 31
	} lane_norm_t;

	function automatic logic [3:0] frac_bits(input logic [1:0] f);
		logic [3:0] r;
		unique case (f)
			FUNC_NONE:    r = 4'd0;
			FUNC_FOUR:    r = 4'd4;
			FUNC_TWELVE:  r = 4'd12;
			FUNC_FIFTEEN: r = 4'd15;
			default:      r = 4'd0;
		endcase
		return r;
	endfunction
endpackage

### rtl/core/f2f_if.sv
// ----------------------------------------------------------------------------
// f2f_if
// Valid/ready channel carrying one item of generic payload.
// ----------------------------------------------------------------------------
interface f2f_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/f2f_lane_norm.sv
// ----------------------------------------------------------------------------
// f2f_lane_norm
// Lane front end: magnitude, leading-one position and normalizing shift.
// ----------------------------------------------------------------------------
module f2f_lane_norm (
	input  logic signed [31:0] value,
	output f2f_pkg::lane_norm_t norm
);
	import f2f_pkg::*;

	logic [31:0] mag;
	logic [4:0]  lz;
	logic        found;

	assign mag = value[31] ? (32'd0 - value) : value;

	always_comb begin
		lz    = 5'd0;
		found = 1'b0;
		for (int i = 31; i >= 0; i--) begin
			if (!found && mag[i]) begin
				lz    = 5'(31 - i);
				found = 1'b1;
			end
		end
	end

	always_comb begin
		norm.zero = (mag == 32'd0);
		norm.sign = value[31];
		norm.top  = 5'd31 - lz;
		norm.norm = mag << lz;
	end
endmodule

### rtl/core/f2f_lane_round.sv
// ----------------------------------------------------------------------------
// f2f_lane_round
// Lane back end: nearest-even rounding to 24 bits and float packing.
// ----------------------------------------------------------------------------
module f2f_lane_round (
	input  f2f_pkg::lane_norm_t norm,
	input  logic [3:0]          fbits,
	output logic [31:0]         result
);
	import f2f_pkg::*;

	logic [24:0] mant;
	logic        guard;
	logic        sticky;
	logic        up;
	logic [7:0]  expo;

	always_comb begin
		guard  = norm.norm[7];
		sticky = |norm.norm[6:0];
		up     = guard && (sticky || norm.norm[8]);
		mant   = {1'b0, norm.norm[31:8]} + {24'd0, up};
		expo   = {3'd0, norm.top} + ExpBias - {4'd0, fbits} + {7'd0, mant[24]};
		if (norm.zero)
			result = 32'd0;
		else if (mant[24])
			result = {norm.sign, expo, 23'd0};
		else
			result = {norm.sign, expo, mant[MantBits-1:0]};
	end
endmodule

### rtl/core/fixed_to_float_vector_convert_unit.sv
// ----------------------------------------------------------------------------
// fixed_to_float_vector_convert_unit
// Four parallel fixed-point to single-precision converters.
// Pipeline: normalize into the stage 1 registers, round into the stage 2 output register.
// Throughput: one item per cycle while the output does not stall; each lane has its own two-stage datapath.
// Reset: arst_n clears the stage valid bits only; no other state.
// ----------------------------------------------------------------------------
module fixed_to_float_vector_convert_unit (
	input  logic clk,
	input  logic arst_n,
	f2f_if.sink   in_ch,
	f2f_if.source out_ch
);
	import f2f_pkg::*;

	in_item_t   item;
	logic       adv_s1;
	logic       adv_s2;
	logic       vld_s1;
	logic       vld_s2;
	logic [3:0] fbits_s1;
	lane_norm_t norm_d [Lanes];
	lane_norm_t norm_s1 [Lanes];
	logic [31:0] res_d [Lanes];
	out_item_t  res_s2;
	logic signed [31:0] lane_in [Lanes];

	assign item = in_ch.data;
	assign lane_in[0] = item.x_in;
	assign lane_in[1] = item.y_in;
	assign lane_in[2] = item.z_in;
	assign lane_in[3] = item.w_in;

	// Stall the pipe only when the output holds an untaken item.
	assign adv_s2   = !vld_s2 || out_ch.ready;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_ch.ready = adv_s1;

	for (genvar g = 0; g < Lanes; g++) begin : g_lane
		f2f_lane_norm u_norm (.value(lane_in[g]), .norm(norm_d[g]));
		f2f_lane_round u_round (.norm(norm_s1[g]), .fbits(fbits_s1), .result(res_d[g]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_ch.valid;
			if (adv_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			fbits_s1 <= frac_bits(item.func);
			norm_s1  <= norm_d;
		end
		// Merge the lane results into one output item.
		if (adv_s2)
			res_s2 <= '{x_out: res_d[0], y_out: res_d[1], z_out: res_d[2], w_out: res_d[3]};
	end

	assign out_ch.valid = vld_s2;
	assign out_ch.data  = res_s2;
endmodule

### dv/tb_fixed_to_float_vector_convert_unit.sv
// ----------------------------------------------------------------------------
// tb_fixed_to_float_vector_convert_unit
// Drives fixed-point vectors into the converter with random gaps and output
// stalls, predicts each float result in the bench and compares every lane.
// ----------------------------------------------------------------------------
module tb_fixed_to_float_vector_convert_unit;
	import f2f_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandItems  = 500;
	localparam int StallLimit = 2000;

	logic clk;
	logic arst_n;

	f2f_if #(.payload_t(in_item_t))  in_ch ();
	f2f_if #(.payload_t(out_item_t)) out_ch ();

	fixed_to_float_vector_convert_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// directed row: input, plus a hand-worked result where one is obvious
	typedef struct {
		in_item_t  stim;
		bit        known;
		out_item_t res;
	} vec_row_t;

	out_item_t float_q[$];
	int        n_errors;
	int        n_sent;
	int        n_recv;
	int        idle_cycles;
	bit        drain_done;
	int        func_hits[4];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Fixed-point lane to single-precision bit pattern, round to nearest even.
	function automatic logic [31:0] fix_to_single(logic signed [31:0] v, logic [1:0] f);
		logic        sgn;
		logic [31:0] mag;
		logic [32:0] sig;
		logic [31:0] rem;
		logic [31:0] half;
		int          msb;
		int          sh;
		int          fb;
		logic [7:0]  ex;
		sgn = v[31];
		mag = sgn ? (32'd0 - v) : v;
		if (mag == 32'd0)
			return 32'd0;
		case (f)
			FUNC_NONE:    fb = 0;
			FUNC_FOUR:    fb = 4;
			FUNC_TWELVE:  fb = 12;
			default:      fb = 15;
		endcase
		msb = 0;
		for (int b = 0; b < 32; b++)
			if (mag[b])
				msb = b;
		if (msb > 23) begin
			sh   = msb - 23;
			rem  = mag & ((32'd1 << sh) - 32'd1);
			half = 32'd1 << (sh - 1);
			sig  = {1'b0, mag >> sh};
			if (rem > half || (rem == half && sig[0]))
				sig = sig + 33'd1;
			// rounding carried past the hidden bit
			if (sig[24]) begin
				sig = sig >> 1;
				msb = msb + 1;
			end
		end else begin
			sig = {1'b0, mag << (23 - msb)};
		end
		ex = 8'(msb + 127 - fb);
		return {sgn, ex, sig[22:0]};
	endfunction

	function automatic out_item_t convert_vector(in_item_t it);
		out_item_t r;
		r.x_out = fix_to_single(it.x_in, it.func);
		r.y_out = fix_to_single(it.y_in, it.func);
		r.z_out = fix_to_single(it.z_in, it.func);
		r.w_out = fix_to_single(it.w_in, it.func);
		return r;
	endfunction

	function automatic logic [31:0] rand_lane();
		logic [31:0] v;
		int          k;
		v = $urandom;
		k = $urandom_range(0, 5);
		case (k)
			0: v = v >> $urandom_range(0, 31);             // small magnitudes
			1: v = $signed(v) >>> $urandom_range(0, 31);   // small, often negative
			2: v = {v[31:8], 8'h80};                      // ties near rounding point
			3: v = (v & 32'hFF00_0000) | 32'h0080_0000;   // exactly representable, bit 23 set
			default: ;
		endcase
		return v;
	endfunction

	// valid stays high across a zero gap; dropped only before a real pause
	task automatic send_item(in_item_t it);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= it;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		float_q.push_back(convert_vector(it));
		func_hits[it.func]++;
		n_sent++;
	endtask

	// Compare one accepted result with the oldest expected vector.
	task automatic check_result(out_item_t got, out_item_t exp);
		if (got !== exp) begin
			n_errors++;
			$display("%0t: result mismatch expected x=%h y=%h z=%h w=%h",
				$time, exp.x_out, exp.y_out, exp.z_out, exp.w_out);
			$display("%0t:                 actual   x=%h y=%h z=%h w=%h",
				$time, got.x_out, got.y_out, got.z_out, got.w_out);
		end
	endtask

	// Sink: random stalls drawn per item, stretches with no stall.
	initial begin
		int wait_n;
		out_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
			if (wait_n > 0) begin
				out_ch.ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid)
				@(posedge clk);
			if (float_q.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result x=%h", $time, out_ch.data.x_out);
			end else begin
				check_result(out_ch.data, float_q.pop_front());
			end
			n_recv++;
		end
	end

	// Watchdog: cycles without any accepted item.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (!drain_done && idle_cycles >= StallLimit) begin
			$display("%0t: watchdog expired, %0d results pending", $time, float_q.size());
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		vec_row_t  dir_tbl[$];
		vec_row_t  row;
		in_item_t  it;
		drain_done   = 1'b0;
		n_errors     = 0;
		n_sent       = 0;
		n_recv       = 0;
		idle_cycles  = 0;
		func_hits    = '{default: 0};
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;

		// zero lanes give +0; extremes with known bit patterns
		row.known = 1'b1;
		row.stim  = '{FUNC_NONE, 32'sd0, 32'sd1, -32'sd1, 32'sh8000_0000};
		row.res   = '{32'h0000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'hCF00_0000};
		dir_tbl.push_back(row);
		row.stim  = '{FUNC_FIFTEEN, 32'sd0, 32'sh7FFF_FFFF, 32'sd32768, 32'sh8000_0000};
		row.res   = '{32'h0000_0000, 32'h4780_0000, 32'h3F80_0000, 32'hC780_0000};
		dir_tbl.push_back(row);
		row.stim  = '{FUNC_FOUR, 32'sd16, -32'sd16, 32'sd1, 32'sd0};
		row.res   = '{32'h3F80_0000, 32'hBF80_0000, 32'h3D80_0000, 32'h0000_0000};
		dir_tbl.push_back(row);
		row.stim  = '{FUNC_TWELVE, 32'sd4096, 32'sd1, -32'sd4096, 32'sd2};
		row.res   = '{32'h3F80_0000, 32'h3980_0000, 32'hBF80_0000, 32'h3A00_0000};
		dir_tbl.push_back(row);
		// rounding: ties to even, carry out of significand, sticky above half
		row.known = 1'b0;
		for (int f = 0; f < 4; f++) begin
			row.stim = '{2'(f), 32'sh0100_0001, 32'sh0100_0003, 32'sh01FF_FFFF,
				32'sh7FFF_FFC0};
			dir_tbl.push_back(row);
			row.stim = '{2'(f), -32'sh0100_0001, 32'sh0100_0002, -32'sh01FF_FFFF,
				32'sh00FF_FFFF};
			dir_tbl.push_back(row);
			row.stim = '{2'(f), 32'shFFFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA,
				32'sh8000_0001};
			dir_tbl.push_back(row);
		end

		repeat (8) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].known && convert_vector(dir_tbl[i].stim) !== dir_tbl[i].res) begin
				n_errors++;
				$display("%0t: table row %0d disagrees with prediction", $time, i);
			end
			send_item(dir_tbl[i].stim);
		end

		for (int n = 0; n < RandItems; n++) begin
			// once mid-run, let the pipe drain completely before going on
			if (n == RandItems / 2) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
				while (float_q.size() != 0)
					@(posedge clk);
			end
			it.func = 2'($urandom_range(0, 3));
			it.x_in = rand_lane();
			it.y_in = rand_lane();
			it.z_in = rand_lane();
			it.w_in = rand_lane();
			send_item(it);
		end
		in_ch.valid <= 1'b0;

		while (float_q.size() != 0)
			@(posedge clk);
		drain_done = 1'b1;
		repeat (10) @(posedge clk);

		$display("Covered %0d vectors (%0d results); per select %0d/%0d/%0d/%0d.",
			n_sent, n_recv, func_hits[0], func_hits[1], func_hits[2], func_hits[3]);
		$display("Mismatches: %0d", n_errors);
		if (n_errors == 0 && float_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
